>>> hdl/ir2d_pkg.sv
// ----------------------------------------------------------------------------
// ir2d_pkg
// Shared constants, codes and controller/datapath interface types for the
// two-digit remote code entry block.
// ----------------------------------------------------------------------------
package ir2d_pkg;

  localparam int NUM_KEYS    = 10;
  localparam int CODE_WIDTH  = 32;
  localparam int DIGIT_LIMIT = 10;
  localparam int SCAN_KEYS   = (NUM_KEYS < DIGIT_LIMIT) ? NUM_KEYS : DIGIT_LIMIT;
  localparam int SCAN_W      = (SCAN_KEYS > 1) ? $clog2(SCAN_KEYS) : 1;
  localparam int TBL_W       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  localparam int ACT_W       = 2;
  localparam int RCODE_W     = 32;
  localparam int SYM_W       = 4;
  localparam int VAL_W       = 7;
  localparam int LI_W        = 4;
  localparam int TMO_W       = 16;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 24;

  localparam logic [SYM_W-1:0] SYM_DASH      = 4'd10;
  localparam logic [SYM_W-1:0] SYM_BLANK     = 4'd11;
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd100;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_CODE  = 2'd1,
    ACT_LEARN = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic apply;
  } dp_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

>>> hdl/ir2d_datapath.sv
// ----------------------------------------------------------------------------
// ir2d_datapath
// Key code table, entry state, timeout counter, table scan and output
// register for the two-digit remote code entry block.
// ----------------------------------------------------------------------------
module ir2d_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ir2d_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [ir2d_pkg::ACT_W-1:0]     in_tuser,
  input  logic                           cfg_wr_en,
  input  logic [ir2d_pkg::TMO_W-1:0]     cfg_wr_data,
  input  ir2d_pkg::dp_cmd_t              cmd,
  output ir2d_pkg::dp_sts_t              sts,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ir2d_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ir2d_pkg::*;

  logic [CODE_WIDTH-1:0] table_r [NUM_KEYS];
  logic [LI_W-1:0]       learn_idx_r, learn_idx_nxt;
  logic                  learn_mode_r, learn_mode_nxt;
  logic                  awaiting_r, awaiting_nxt;
  logic [VAL_W-1:0]      partial_r, partial_nxt;
  logic [TMO_W-1:0]      tout_cnt_r, tout_cnt_nxt;
  logic [SYM_W-1:0]      left_r, left_nxt;
  logic [SYM_W-1:0]      right_r, right_nxt;
  logic [TMO_W-1:0]      timeout_r;
  logic [ACT_W-1:0]      action_r;
  logic [CODE_WIDTH-1:0] code_r;
  logic [SCAN_W-1:0]     scan_idx_r;
  logic                  hit_r;
  logic [SYM_W-1:0]      hit_dig_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                  cur_match;
  logic                  scan_last;
  logic                  tbl_we;
  logic [LI_W-1:0]       li_inc;
  logic [TMO_W-1:0]      tc_inc;
  logic                  ent_valid;
  logic [VAL_W-1:0]      ent_value;
  logic [VAL_W-1:0]      dig_ext;

  assign cur_match = (table_r[TBL_W'(scan_idx_r)] == code_r);
  assign scan_last = (scan_idx_r == SCAN_W'(SCAN_KEYS - 1));

  assign sts.need_scan = (action_r == ACT_CODE) && !learn_mode_r;
  assign sts.scan_done = cur_match || scan_last;
  assign sts.out_free  = !out_valid_r || out_tready;

  assign li_inc  = learn_idx_r + LI_W'(1);
  assign tc_inc  = (tout_cnt_r != {TMO_W{1'b1}}) ? tout_cnt_r + TMO_W'(1) : tout_cnt_r;
  assign dig_ext = VAL_W'(hit_dig_r);

  always_comb begin
    learn_idx_nxt  = learn_idx_r;
    learn_mode_nxt = learn_mode_r;
    awaiting_nxt   = awaiting_r;
    partial_nxt    = partial_r;
    tout_cnt_nxt   = tout_cnt_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    tbl_we         = 1'b0;
    ent_valid      = 1'b0;
    ent_value      = '0;
    case (action_r)
      ACT_LEARN: begin
        learn_mode_nxt = 1'b1;
        learn_idx_nxt  = '0;
        awaiting_nxt   = 1'b0;
        tout_cnt_nxt   = '0;
        left_nxt       = SYM_DASH;
        right_nxt      = SYM_DASH;
      end
      ACT_TICK: begin
        if (!learn_mode_r && awaiting_r) begin
          tout_cnt_nxt = tc_inc;
          if (tc_inc >= timeout_r) begin
            awaiting_nxt = 1'b0;
            left_nxt     = SYM_BLANK;
            right_nxt    = SYM_BLANK;
          end
        end
      end
      ACT_CODE: begin
        if (learn_mode_r) begin
          tbl_we = ({1'b0, learn_idx_r} < (LI_W + 1)'(NUM_KEYS));
          if (learn_idx_r >= LI_W'(10)) begin
            left_nxt  = SYM_W'(1);
            right_nxt = SYM_W'(learn_idx_r - LI_W'(10));
          end else begin
            left_nxt  = '0;
            right_nxt = SYM_W'(learn_idx_r);
          end
          learn_idx_nxt = li_inc;
          if (({1'b0, li_inc} >= (LI_W + 1)'(NUM_KEYS)) || (li_inc == '0)) begin
            learn_mode_nxt = 1'b0;
            learn_idx_nxt  = '0;
          end
        end else if (hit_r) begin
          if (awaiting_r) begin
            ent_valid    = 1'b1;
            ent_value    = partial_r + dig_ext;
            right_nxt    = hit_dig_r;
            awaiting_nxt = 1'b0;
          end else begin
            left_nxt     = hit_dig_r;
            right_nxt    = SYM_DASH;
            partial_nxt  = (dig_ext << 3) + (dig_ext << 1);
            tout_cnt_nxt = '0;
            awaiting_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        table_r[k] <= '0;
      end
      learn_idx_r  <= '0;
      learn_mode_r <= 1'b0;
      awaiting_r   <= 1'b0;
      partial_r    <= '0;
      tout_cnt_r   <= '0;
      left_r       <= SYM_BLANK;
      right_r      <= SYM_BLANK;
      timeout_r    <= TIMEOUT_RESET;
      out_valid_r  <= 1'b0;
      hit_r        <= 1'b0;
      scan_idx_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (cmd.load) begin
        scan_idx_r <= '0;
        hit_r      <= 1'b0;
      end else if (cmd.scan_step) begin
        if (cur_match) begin
          hit_r <= 1'b1;
        end
        if (!scan_last) begin
          scan_idx_r <= scan_idx_r + SCAN_W'(1);
        end
      end
      if (cmd.apply) begin
        if (tbl_we) begin
          table_r[TBL_W'(learn_idx_r)] <= code_r;
        end
        learn_idx_r  <= learn_idx_nxt;
        learn_mode_r <= learn_mode_nxt;
        awaiting_r   <= awaiting_nxt;
        partial_r    <= partial_nxt;
        tout_cnt_r   <= tout_cnt_nxt;
        left_r       <= left_nxt;
        right_r      <= right_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_tuser;
      code_r   <= CODE_WIDTH'(in_tdata[RCODE_W-1:0]);
    end
    if (cmd.scan_step && cur_match) begin
      hit_dig_r <= SYM_W'(scan_idx_r);
    end
    if (cmd.apply) begin
      out_data_r <= {(OUT_DATA_W - 2 * SYM_W - 2 - VAL_W)'(0), ent_value, ent_valid,
                     learn_mode_nxt, right_nxt, left_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> hdl/ir2d_ctrl.sv
// ----------------------------------------------------------------------------
// ir2d_ctrl
// Sequencer for the two-digit remote code entry block: accepts an item, walks
// the code table when a digit lookup is needed and commits the result.
// ----------------------------------------------------------------------------
module ir2d_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output ir2d_pkg::dp_cmd_t cmd,
  input  ir2d_pkg::dp_sts_t sts
);
  import ir2d_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    cmd.load      = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.apply     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts.need_scan) begin
          state_nxt = ST_APPLY;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_done) begin
            state_nxt = ST_APPLY;
          end
        end
      end
      ST_APPLY: begin
        if (sts.out_free) begin
          cmd.apply = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> hdl/ir_two_digit_code_entry_core.sv
// ----------------------------------------------------------------------------
// ir_two_digit_code_entry_core
// Turns remote key codes, learn requests and ticks into two-digit entries
// and display symbols, with a learnable table of digit key codes.
//
// Channel  Direction  Contents
// in_      slave      tdata: remote_code; tuser: action
// out_     master     tdata: left_symbol, right_symbol, learning_active,
//                            entry_valid, entry_value
// cfg_     write      entry_timeout_ticks
//
// Each item passes through the accept, scan and commit states. For a received
// digit code the scan state walks the ten-entry code table one entry per
// cycle, stopping at the first match. A new item is taken once the previous
// one is committed to the output register. A stalled output holds the next
// result in the commit state. Synchronous reset clears the table to zero.
// ----------------------------------------------------------------------------
module ir_two_digit_code_entry_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] remote_code
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [3:0] left_symbol, [7:4] right_symbol,
                                  // [8] learning_active, [9] entry_valid,
                                  // [16:10] entry_value, [23:17] zero
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import ir2d_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ir2d_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ir2d_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

>>> verif/ir_two_digit_code_entry_checker.sv
// ----------------------------------------------------------------------------
// ir_two_digit_code_entry_checker
// Watches the input, result and register channels of the two-digit code
// entry block. It keeps its own copy of the key table, the entry state and
// the timeout register. For every accepted input item it works out the
// display result. Each result the block hands over is compared field by
// field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module ir_two_digit_code_entry_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [ir2d_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [ir2d_pkg::ACT_W-1:0]      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [ir2d_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [ir2d_pkg::TMO_W-1:0]      cfg_wr_data,
  output int                              fail_count,
  output int                              pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import ir2d_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0] left_sym;
    logic [SYM_W-1:0] right_sym;
    logic             learning;
    logic             entry_valid;
    logic [VAL_W-1:0] entry_value;
  } display_t;

  logic [CODE_WIDTH-1:0] key_codes [NUM_KEYS];
  logic [LI_W-1:0]       learn_idx;
  logic                  learn_on;
  logic                  first_held;
  logic [VAL_W-1:0]      tens_value;
  logic [TMO_W-1:0]      tick_count;
  logic [SYM_W-1:0]      left_now;
  logic [SYM_W-1:0]      right_now;
  logic [TMO_W-1:0]      tick_limit;
  display_t              display_q [$];

  task automatic decode_item(input logic [ACT_W-1:0] act, input logic [RCODE_W-1:0] raw,
                             output display_t res);
    logic [CODE_WIDTH-1:0] code;
    int                    hit;
    res = '0;
    code = raw[CODE_WIDTH-1:0];
    hit = -1;
    case (act)
      ACT_LEARN: begin
        learn_on = 1'b1;
        learn_idx = '0;
        first_held = 1'b0;
        tick_count = '0;
        left_now = SYM_DASH;
        right_now = SYM_DASH;
      end
      ACT_TICK: begin
        if (!learn_on && first_held) begin
          if (tick_count != '1) tick_count = tick_count + 1'b1;
          if (tick_count >= tick_limit) begin
            first_held = 1'b0;
            left_now = SYM_BLANK;
            right_now = SYM_BLANK;
          end
        end
      end
      ACT_CODE: begin
        if (learn_on) begin
          if (learn_idx < NUM_KEYS) key_codes[learn_idx] = code;
          left_now = SYM_W'((learn_idx / 10) % 10);
          right_now = SYM_W'(learn_idx % 10);
          learn_idx = learn_idx + 1'b1;
          if (learn_idx >= NUM_KEYS || learn_idx == 0) begin
            learn_on = 1'b0;
            learn_idx = '0;
          end
        end else begin
          for (int k = 0; k < SCAN_KEYS; k++) begin
            if (hit < 0 && key_codes[k] == code) hit = k;
          end
          if (hit >= 0) begin
            if (first_held) begin
              res.entry_value = VAL_W'(tens_value + hit);
              res.entry_valid = 1'b1;
              right_now = SYM_W'(hit);
              first_held = 1'b0;
            end else begin
              left_now = SYM_W'(hit);
              right_now = SYM_DASH;
              tens_value = VAL_W'(10 * hit);
              tick_count = '0;
              first_held = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.left_sym = left_now;
    res.right_sym = right_now;
    res.learning = learn_on;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    display_t want;
    display_t got;
    if (!rst_n) begin
      foreach (key_codes[k]) key_codes[k] = '0;
      learn_idx = '0;
      learn_on = 1'b0;
      first_held = 1'b0;
      tens_value = '0;
      tick_count = '0;
      left_now = SYM_BLANK;
      right_now = SYM_BLANK;
      tick_limit = TIMEOUT_RESET;
      display_q.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (cfg_wr_en) tick_limit = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        decode_item(in_tuser, in_tdata[RCODE_W-1:0], want);
        display_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.left_sym = out_tdata[3:0];
        got.right_sym = out_tdata[7:4];
        got.learning = out_tdata[8];
        got.entry_valid = out_tdata[9];
        got.entry_value = out_tdata[16:10];
        if (display_q.size() == 0) begin
          $display("%0t: result with none expected, actual %h", $time, out_tdata);
          fail_count++;
        end else begin
          want = display_q.pop_front();
          check_field("left_symbol", want.left_sym, got.left_sym);
          check_field("right_symbol", want.right_sym, got.right_sym);
          check_field("learning_active", want.learning, got.learning);
          check_field("entry_valid", want.entry_valid, got.entry_valid);
          check_field("entry_value", want.entry_value, got.entry_value);
          check_field("padding", 0, out_tdata[OUT_DATA_W-1:17]);
        end
      end
      pending <= display_q.size();
    end
  end

endmodule

>>> verif/ir_two_digit_code_entry_core_tb.sv
// ----------------------------------------------------------------------------
// ir_two_digit_code_entry_core_tb
// Drives key codes, learn requests and ticks into the two-digit code entry
// block. A short directed part covers the unlearned table, learning with a
// restart and duplicate codes. Random phases follow, each under its own
// timeout setting and one of four idling patterns, with one long output
// hold-off. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module ir_two_digit_code_entry_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ir2d_pkg::*;

  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;
  localparam int               IDLE_LIMIT = 4000;
  localparam int               PHASES     = 7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [ACT_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [TMO_W-1:0]      cfg_wr_data = '0;
  int                    fail_count;
  int                    pending;

  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  logic                  recv_hold = 1'b0;
  int                    items_sent = 0;
  int                    quiet_cycles = 0;
  logic [CODE_WIDTH-1:0] taught [NUM_KEYS];

  ir_two_digit_code_entry_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  ir_two_digit_code_entry_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || recv_hold) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic push_item(input logic [ACT_W-1:0] act, input logic [IN_DATA_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TMO_W-1:0] ticks);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= ticks;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // A broken sequence learns a few random codes, then a clean relearn follows.
  task automatic teach_keys(input bit broken);
    logic [CODE_WIDTH-1:0] code;
    int                    pick;
    if (broken) begin
      push_item(ACT_LEARN, $urandom);
      repeat ($urandom_range(1, NUM_KEYS - 1)) push_item(ACT_CODE, $urandom);
    end
    push_item(ACT_LEARN, $urandom);
    for (int k = 0; k < NUM_KEYS; k++) begin
      if ($urandom_range(9) == 0) push_item(ACT_TICK, $urandom);
      if ($urandom_range(19) == 0) push_item(ACT_NONE, $urandom);
      pick = $urandom_range(9);
      if (pick < 3) code = $urandom_range(15);
      else if (pick == 3 && k > 0) code = taught[$urandom_range(k - 1)];
      else code = $urandom;
      taught[k] = code;
      push_item(ACT_CODE, code);
    end
  endtask

  task automatic random_item;
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) push_item(ACT_CODE, taught[$urandom_range(NUM_KEYS - 1)]);
    else if (roll < 72) repeat ($urandom_range(1, 4)) push_item(ACT_TICK, $urandom);
    else if (roll < 84) push_item(ACT_CODE, $urandom);
    else if (roll < 92) push_item(ACT_NONE, $urandom);
    else if (roll < 96) teach_keys(1'b0);
    else teach_keys(1'b1);
  endtask

  initial begin
    logic [CODE_WIDTH-1:0] key_list [NUM_KEYS];
    int                    tmo_list [PHASES];
    int                    target;
    key_list = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001,
                 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h1234_5678, 32'h5A5A_5A5A,
                 32'h7FFF_FFFF, 32'hFFFF_FFFE};
    tmo_list = '{3, 1, 0, 65535, 2, 7, 100};
    foreach (taught[k]) taught[k] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_item(ACT_CODE, 32'h0000_0000);
    push_item(ACT_NONE, 32'hFFFF_FFFF);
    push_item(ACT_CODE, 32'h0000_0000);
    push_item(ACT_CODE, 32'hDEAD_BEEF);
    push_item(ACT_LEARN, 32'h0000_0000);
    push_item(ACT_TICK, 32'hFFFF_FFFF);
    push_item(ACT_CODE, 32'h0000_0003);
    push_item(ACT_CODE, 32'h0000_0004);
    push_item(ACT_LEARN, 32'hFFFF_FFFF);
    for (int k = 0; k < NUM_KEYS; k++) begin
      taught[k] = key_list[k];
      push_item(ACT_CODE, key_list[k]);
    end
    push_item(ACT_CODE, 32'hFFFF_FFFE);
    push_item(ACT_CODE, 32'hFFFF_FFFE);
    push_item(ACT_CODE, 32'h5A5A_5A5A);
    push_item(ACT_TICK, 32'h0000_0000);
    push_item(ACT_CODE, 32'h0000_0000);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_timeout(TMO_W'(tmo_list[p]));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 75; end
        default: begin send_idle_pct = 14; recv_stall_pct <= 14; end
      endcase
      if (p == 4) begin
        send_idle_pct = 0;
        fork
          begin
            recv_hold <= 1'b1;
            repeat (300) @(posedge clk);
            recv_hold <= 1'b0;
          end
        join_none
      end
      target = items_sent + 62;
      while (items_sent < target) random_item();
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> ir_two_digit_code_entry_core.f
hdl/ir2d_pkg.sv
hdl/ir2d_datapath.sv
hdl/ir2d_ctrl.sv
hdl/ir_two_digit_code_entry_core.sv
verif/ir_two_digit_code_entry_checker.sv
verif/ir_two_digit_code_entry_core_tb.sv
